>>> hdl/irtx_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// irtx_pkg
// shared types and constants of the ir pulse frame transmitter
// ---------------------------------------------------------------------------
package irtx_pkg;

  localparam int TICK_W     = 16;
  localparam int BYTE_W     = 8;
  localparam int WORD_W     = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int PHASE_W    = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_MARK  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEADER_SPACE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_MARK     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ONE_SPACE    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ZERO_SPACE   = 3'd4;

  // register reset values, half-microsecond ticks
  localparam logic [TICK_W-1:0] RST_LEADER_MARK  = 16'd18000;
  localparam logic [TICK_W-1:0] RST_LEADER_SPACE = 16'd9000;
  localparam logic [TICK_W-1:0] RST_BIT_MARK     = 16'd1125;
  localparam logic [TICK_W-1:0] RST_ONE_SPACE    = 16'd3375;
  localparam logic [TICK_W-1:0] RST_ZERO_SPACE   = 16'd1125;

  // envelope phases
  localparam logic [PHASE_W-1:0] PH_IDLE        = 3'd0;
  localparam logic [PHASE_W-1:0] PH_LEAD_MARK   = 3'd1;
  localparam logic [PHASE_W-1:0] PH_LEAD_SPACE  = 3'd2;
  localparam logic [PHASE_W-1:0] PH_BIT_MARK    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_BIT_SPACE   = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CLOSE_MARK  = 3'd5;

  // operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  typedef struct packed {
    logic [TICK_W-1:0] leader_mark;
    logic [TICK_W-1:0] leader_space;
    logic [TICK_W-1:0] bit_mark;
    logic [TICK_W-1:0] one_space;
    logic [TICK_W-1:0] zero_space;
  } irtx_timing_t;

endpackage
`default_nettype wire

>>> hdl/irtx_regs.sv
`default_nettype none
// ---------------------------------------------------------------------------
// irtx_regs
// timing register file, written through the configuration channel
// ---------------------------------------------------------------------------
module irtx_regs (
  input  wire                                  clk,
  input  wire                                  rst,
  input  wire                                  cfg_valid,
  output logic                                 cfg_ready,
  input  wire  [irtx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire  [irtx_pkg::TICK_W-1:0]          cfg_data,
  output irtx_pkg::irtx_timing_t               timing
);
  import irtx_pkg::*;

  irtx_timing_t regs;

  assign cfg_ready = 1'b1;
  assign timing    = regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.leader_mark  <= RST_LEADER_MARK;
      regs.leader_space <= RST_LEADER_SPACE;
      regs.bit_mark     <= RST_BIT_MARK;
      regs.one_space    <= RST_ONE_SPACE;
      regs.zero_space   <= RST_ZERO_SPACE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LEADER_MARK:  regs.leader_mark  <= cfg_data;
        REG_LEADER_SPACE: regs.leader_space <= cfg_data;
        REG_BIT_MARK:     regs.bit_mark     <= cfg_data;
        REG_ONE_SPACE:    regs.one_space    <= cfg_data;
        REG_ZERO_SPACE:   regs.zero_space   <= cfg_data;
        default: ;  // writes beyond the list are dropped
      endcase
    end
  end

endmodule
`default_nettype wire

>>> hdl/ir_pulse_frame_transmitter.sv
`default_nettype none
// ---------------------------------------------------------------------------
// ir_pulse_frame_transmitter
// pulse-distance ir frame envelope generator with nec-style timing
// ---------------------------------------------------------------------------
// A start item (operation = 1) loads the word x<<24 | y<<16 | heading<<8 |
// checksum, where checksum = x ^ y ^ heading, and arms a frame. Each tick
// item (operation = 0) then advances the envelope by one timebase tick:
// leader mark, leader space, FRAME_BITS bits sent lsb first (a bit mark,
// then a long space for a one or a short space for a zero), and a closing
// mark. Every item gives exactly one result: carrier_on tells whether that
// tick lies in a mark, busy_res whether a frame was running or the item
// was a start, frame_done flags the tick that ends the closing mark, and
// start_ignored flags a start that arrived while a frame was running. A phase
// length of N ticks gives N ticks; a length of zero gives one. Register
// writes take effect at the next phase load. The block takes one item per
// clock unless item_stall is raised, and shows its result in the cycle
// after acceptance; the envelope state (phase, tick counter, bit counter,
// shift register) is updated on acceptance by a 16-bit decrement and a
// phase select. A result register holds the last result while the output
// side stalls; item_stall is raised only while that register is full and
// stalled, so a fresh item is taken in the same cycle the held result leaves.
// ---------------------------------------------------------------------------
module ir_pulse_frame_transmitter #(
  parameter int FRAME_BITS = 32
) (
  input  wire                                clk,
  input  wire                                rst,
  // item channel
  input  wire                                item_valid,
  output logic                               item_stall,
  input  wire                                operation,
  input  wire  [irtx_pkg::BYTE_W-1:0]        x_byte,
  input  wire  [irtx_pkg::BYTE_W-1:0]        y_byte,
  input  wire  [irtx_pkg::BYTE_W-1:0]        heading_byte,
  // result channel
  output logic                               result_valid,
  input  wire                                result_stall,
  output logic                               carrier_on,
  output logic                               busy_res,
  output logic                               frame_done,
  output logic                               start_ignored,
  // configuration channel
  input  wire                                cfg_valid,
  output logic                               cfg_ready,
  input  wire  [irtx_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire  [irtx_pkg::TICK_W-1:0]        cfg_data
);
  import irtx_pkg::*;

  // bit counter wide enough to hold the frame length
  localparam int CNT_W = $clog2(FRAME_BITS + 1);
  localparam logic [CNT_W-1:0] LAST_BIT = CNT_W'(FRAME_BITS - 1);

  irtx_timing_t timing;

  irtx_regs u_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .timing    (timing)
  );

  // envelope state
  logic [PHASE_W-1:0] phase, phase_next;
  logic [CNT_W-1:0]   bits_sent, bits_sent_next;
  logic [TICK_W-1:0]  ticks_left, ticks_left_next;
  logic [WORD_W-1:0]  frame_shift, frame_shift_next;

  // result of the item at the input
  logic carrier_next, busy_next, done_next, ignored_next;

  logic accept;
  logic [BYTE_W-1:0] checksum;

  // the result register frees up when it is empty or being taken
  assign item_stall = result_valid && result_stall;
  assign accept     = item_valid && !item_stall;
  assign checksum   = x_byte ^ y_byte ^ heading_byte;

  always_comb begin
    phase_next       = phase;
    bits_sent_next   = bits_sent;
    ticks_left_next  = ticks_left;
    frame_shift_next = frame_shift;
    carrier_next     = 1'b0;
    busy_next        = 1'b0;
    done_next        = 1'b0;
    ignored_next     = 1'b0;

    if (operation == OP_START) begin
      busy_next = 1'b1;
      if (phase != PH_IDLE) begin
        // frame already running, leave it alone
        ignored_next = 1'b1;
      end else begin
        frame_shift_next = {x_byte, y_byte, heading_byte, checksum};
        bits_sent_next   = '0;
        phase_next       = PH_LEAD_MARK;
        ticks_left_next  = timing.leader_mark;
      end
    end else if (phase != PH_IDLE) begin
      busy_next    = 1'b1;
      carrier_next = (phase == PH_LEAD_MARK) || (phase == PH_BIT_MARK) ||
                     (phase == PH_CLOSE_MARK);
      if (ticks_left > 16'd1) begin
        ticks_left_next = ticks_left - 16'd1;
      end else begin
        // last tick of the phase: load the next one
        unique case (phase)
          PH_LEAD_MARK: begin
            phase_next      = PH_LEAD_SPACE;
            ticks_left_next = timing.leader_space;
          end
          PH_LEAD_SPACE: begin
            phase_next      = PH_BIT_MARK;
            ticks_left_next = timing.bit_mark;
          end
          PH_BIT_MARK: begin
            phase_next      = PH_BIT_SPACE;
            ticks_left_next = frame_shift[0] ? timing.one_space : timing.zero_space;
          end
          PH_BIT_SPACE: begin
            // bits past the loaded word shift in as zeros
            frame_shift_next = {1'b0, frame_shift[WORD_W-1:1]};
            bits_sent_next   = bits_sent + CNT_W'(1);
            phase_next       = (bits_sent == LAST_BIT) ? PH_CLOSE_MARK : PH_BIT_MARK;
            ticks_left_next  = timing.bit_mark;
          end
          default: begin
            // closing mark finished
            phase_next      = PH_IDLE;
            ticks_left_next = '0;
            done_next       = 1'b1;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      bits_sent   <= '0;
      ticks_left  <= '0;
      frame_shift <= '0;
    end else if (accept) begin
      phase       <= phase_next;
      bits_sent   <= bits_sent_next;
      ticks_left  <= ticks_left_next;
      frame_shift <= frame_shift_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      carrier_on    <= carrier_next;
      busy_res      <= busy_next;
      frame_done    <= done_next;
      start_ignored <= ignored_next;
    end
  end

  // every accepted item leaves a result behind
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> result_valid)
    else $error("accepted item produced no result");

  // carrier or frame end only while a frame runs
  a_carrier_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && (carrier_on || frame_done) |-> busy_res)
    else $error("carrier or frame end reported while not busy");

  // an ignored start never drives the envelope
  a_ignored_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && start_ignored |-> busy_res && !carrier_on && !frame_done)
    else $error("ignored start reported envelope activity");

  // idle phase keeps a cleared tick counter
  a_idle_cleared: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> ticks_left == '0)
    else $error("tick counter left nonzero while idle");

  // a finished frame returns to idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    accept && done_next |=> phase == PH_IDLE)
    else $error("frame end did not return to idle");

endmodule
`default_nettype wire
